[rtl/cssesc_pkg.sv]
// Shared types, character constants and helpers for the CSS identifier escaper.
package cssesc_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] CHAR_NUL       = 16'h0000;
    localparam logic [15:0] CHAR_SPACE     = 16'h0020;
    localparam logic [15:0] CHAR_DASH      = 16'h002D;
    localparam logic [15:0] CHAR_BACKSLASH = 16'h005C;
    localparam logic [15:0] CTRL_LIMIT     = 16'h0020;
    localparam logic [15:0] CHAR_DEL       = 16'h007F;
    localparam logic [15:0] C1_LIMIT       = 16'h00A0;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        first_of_ident;
        logic        last_of_ident;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_unit;
        logic        ident_failed;
        logic        last_of_run;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_PLAIN,
        CMD_BSLASH,
        CMD_HEX,
        CMD_FAIL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] unit;
    } cmd_t;

    function automatic logic [15:0] hex_digit(input logic [3:0] nib);
        logic [15:0] wide;
        wide = {12'b0, nib};
        if (nib < 4'd10)
        begin
            hex_digit = 16'h0030 + wide;
        end
        else
        begin
            hex_digit = 16'h0057 + wide;
        end
    endfunction

endpackage

[rtl/cssesc_front.sv]
// Front end: tracks identifier position and classifies each code unit into an escape command.
module cssesc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  cssesc_pkg::in_item_t item,
    output logic                 cmd_valid,
    output cssesc_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        PH_START,
        PH_DASH,
        PH_BODY
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;
    logic   aborted_reg;
    logic   aborted_next;

    phase_t      phase_eff;
    logic        aborted_eff;
    logic [15:0] ch;
    logic        is_digit;
    logic        is_plain;
    logic        is_ctrl;

    assign ch = item.code_unit;
    assign is_digit = (ch >= 16'h0030) && (ch <= 16'h0039);
    assign is_plain = is_digit || (ch == 16'h005F) || (ch == cssesc_pkg::CHAR_DASH) ||
                      ((ch >= 16'h0041) && (ch <= 16'h005A)) ||
                      ((ch >= 16'h0061) && (ch <= 16'h007A));
    assign is_ctrl = (ch < cssesc_pkg::CTRL_LIMIT) ||
                     ((ch >= cssesc_pkg::CHAR_DEL) && (ch < cssesc_pkg::C1_LIMIT));

    always_comb
    begin
        phase_eff   = item.first_of_ident ? PH_START : phase_reg;
        aborted_eff = item.first_of_ident ? 1'b0 : aborted_reg;
        phase_next  = phase_eff;
        aborted_next = aborted_eff;
        cmd_valid   = 1'b0;
        cmd.kind    = cssesc_pkg::CMD_PLAIN;
        cmd.unit    = ch;
        if (aborted_eff)
        begin
            cmd_valid = 1'b0;
        end
        else if ((phase_eff == PH_START) && (ch == cssesc_pkg::CHAR_DASH))
        begin
            cmd_valid  = 1'b1;
            cmd.kind   = item.last_of_ident ? cssesc_pkg::CMD_BSLASH : cssesc_pkg::CMD_PLAIN;
            phase_next = PH_DASH;
        end
        else if (((phase_eff == PH_START) || (phase_eff == PH_DASH)) && is_digit)
        begin
            cmd_valid  = 1'b1;
            cmd.kind   = cssesc_pkg::CMD_HEX;
            phase_next = PH_BODY;
        end
        else
        begin
            cmd_valid  = 1'b1;
            phase_next = PH_BODY;
            if (ch == cssesc_pkg::CHAR_NUL)
            begin
                cmd.kind     = cssesc_pkg::CMD_FAIL;
                aborted_next = 1'b1;
            end
            else if (is_ctrl)
            begin
                cmd.kind = cssesc_pkg::CMD_HEX;
            end
            else if ((ch < cssesc_pkg::CHAR_DEL) && !is_plain)
            begin
                cmd.kind = cssesc_pkg::CMD_BSLASH;
            end
            else
            begin
                cmd.kind = cssesc_pkg::CMD_PLAIN;
            end
        end
        if (item.last_of_ident)
        begin
            phase_next   = PH_START;
            aborted_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            aborted_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            aborted_reg <= aborted_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        aborted_reg |-> (phase_reg == PH_BODY))
        else $error("Aborted identifier is not in the body phase.");

endmodule

[rtl/cssesc_cmd_queue.sv]
// Short command queue between the classifier and the escape sequencer.
module cssesc_cmd_queue
#(
    parameter int DEPTH = cssesc_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  cssesc_pkg::cmd_t wr_data,
    input  logic             rd_en,
    output cssesc_pkg::cmd_t rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    cssesc_pkg::cmd_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("Command queue count exceeds its depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("Command queue lost a write.");

endmodule

[rtl/cssesc_back.sv]
// Back end: expands each command into escaped code units behind an output register.
module cssesc_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cssesc_pkg::cmd_t      head,
    input  logic                  head_valid,
    output logic                  head_done,
    input  logic                  pop,
    output logic                  empty,
    output cssesc_pkg::out_item_t result
);

    logic [1:0]            step_reg;
    logic [1:0]            step_next;
    logic                  out_valid_reg;
    cssesc_pkg::out_item_t result_reg;
    cssesc_pkg::out_item_t res;
    logic                  load;
    logic                  two_digit;
    logic [15:0]           hi_char;
    logic [15:0]           lo_char;

    assign two_digit = (head.unit[7:4] != 4'd0);
    assign hi_char   = cssesc_pkg::hex_digit(head.unit[7:4]);
    assign lo_char   = cssesc_pkg::hex_digit(head.unit[3:0]);

    always_comb
    begin
        res.out_unit     = head.unit;
        res.ident_failed = 1'b0;
        res.last_of_run  = 1'b0;
        case (head.kind)
            cssesc_pkg::CMD_PLAIN:
            begin
                res.last_of_run = 1'b1;
            end
            cssesc_pkg::CMD_BSLASH:
            begin
                if (step_reg == 2'd0)
                begin
                    res.out_unit = cssesc_pkg::CHAR_BACKSLASH;
                end
                else
                begin
                    res.last_of_run = 1'b1;
                end
            end
            cssesc_pkg::CMD_FAIL:
            begin
                res.out_unit     = cssesc_pkg::CHAR_NUL;
                res.ident_failed = 1'b1;
                res.last_of_run  = 1'b1;
            end
            cssesc_pkg::CMD_HEX:
            begin
                case (step_reg)
                    2'd0:
                    begin
                        res.out_unit = cssesc_pkg::CHAR_BACKSLASH;
                    end
                    2'd1:
                    begin
                        res.out_unit = two_digit ? hi_char : lo_char;
                    end
                    2'd2:
                    begin
                        res.out_unit    = two_digit ? lo_char : cssesc_pkg::CHAR_SPACE;
                        res.last_of_run = !two_digit;
                    end
                    default:
                    begin
                        res.out_unit    = cssesc_pkg::CHAR_SPACE;
                        res.last_of_run = 1'b1;
                    end
                endcase
            end
            default:
            begin
                res.last_of_run = 1'b1;
            end
        endcase
    end

    assign load      = head_valid && (!out_valid_reg || pop);
    assign head_done = load && res.last_of_run;
    assign step_next = res.last_of_run ? 2'd0 : step_reg + 2'd1;
    assign empty     = !out_valid_reg;
    assign result    = result_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg      <= step_next;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != 2'd0) |-> head_valid)
        else $error("Command left the queue in the middle of its expansion.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.ident_failed) |->
            (result_reg.last_of_run && (result_reg.out_unit == cssesc_pkg::CHAR_NUL)))
        else $error("Failure marker is malformed.");

endmodule

[rtl/css_identifier_escaper_core.sv]
// Top level of the CSS identifier escaper.
// The block takes one UTF-16 code unit per transaction on its input queue interface and emits
// the escaped identifier one code unit per transaction on its result queue interface. A unit
// that passes through or needs only a backslash costs one or two results, a hex escape
// three or four, a failure marker one, and a unit dropped after a NUL none. The input side
// accepts one unit per cycle as long as the command queue between the classifier and the escape
// sequencer has room; sustained throughput is set by the sequencer, which emits one result per
// cycle while results are popped, so plain text streams at one unit per cycle and multi-unit
// escapes slow the input only once the queue of QUEUE_DEPTH commands has filled. last_of_run
// marks the final result of each input unit, and ident_failed marks the failure marker.
module css_identifier_escaper_core
#(
    parameter int QUEUE_DEPTH = cssesc_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  cssesc_pkg::in_item_t  item,
    output logic                  empty,
    input  logic                  pop,
    output cssesc_pkg::out_item_t result
);

    logic             accept;
    logic             cmd_valid;
    cssesc_pkg::cmd_t cmd;
    cssesc_pkg::cmd_t head;
    logic             q_empty;
    logic             head_done;

    assign accept = push && !full;

    cssesc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    cssesc_cmd_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && cmd_valid),
        .wr_data (cmd),
        .rd_en   (head_done),
        .rd_data (head),
        .full    (full),
        .empty   (q_empty)
    );

    cssesc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_empty),
        .head_done  (head_done),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

[bench/css_identifier_escaper_core_test.sv]
// Self-checking testbench for the CSS identifier escaper core.
`timescale 1ns / 1ps

module css_identifier_escaper_core_test;

    localparam logic [15:0] CHAR_ZERO       = 16'h0030;
    localparam logic [15:0] CHAR_NINE       = 16'h0039;
    localparam logic [15:0] CHAR_UPPER_A    = 16'h0041;
    localparam logic [15:0] CHAR_UPPER_Z    = 16'h005A;
    localparam logic [15:0] CHAR_UNDERSCORE = 16'h005F;
    localparam logic [15:0] CHAR_LOWER_A    = 16'h0061;
    localparam logic [15:0] CHAR_LOWER_Z    = 16'h007A;
    localparam logic [15:0] CHAR_TILDE      = 16'h007E;
    localparam int          LONG_HOLD       = 200;

    typedef enum logic [1:0] {
        AT_START,
        AFTER_DASH,
        IN_BODY
    } ident_phase_t;

    class escape_scoreboard;
        ident_phase_t          phase;
        bit                    dropping;
        int                    mismatches;
        cssesc_pkg::out_item_t awaited[$];
        cssesc_pkg::out_item_t run_units[$];

        function new();
            phase = AT_START;
            dropping = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            $display("mismatch at %0t ns: %s", $time, what);
        endtask

        function void stage(input logic [15:0] unit, input logic failed);
            cssesc_pkg::out_item_t r;
            r.out_unit = unit;
            r.ident_failed = failed;
            r.last_of_run = 1'b0;
            run_units.push_back(r);
        endfunction

        function void stage_hex_escape(input logic [15:0] ch);
            bit         started;
            logic [3:0] nib;
            started = 1'b0;
            stage(cssesc_pkg::CHAR_BACKSLASH, 1'b0);
            for (int s = 12; s >= 0; s -= 4)
            begin
                nib = ch[s +: 4];
                if (nib != 4'd0 || started || s == 0)
                begin
                    started = 1'b1;
                    if (nib < 4'd10)
                    begin
                        stage(CHAR_ZERO + 16'(nib), 1'b0);
                    end
                    else
                    begin
                        stage(CHAR_LOWER_A + 16'(nib) - 16'd10, 1'b0);
                    end
                end
            end
            stage(cssesc_pkg::CHAR_SPACE, 1'b0);
        endfunction

        function bit is_digit(input logic [15:0] ch);
            return ch >= CHAR_ZERO && ch <= CHAR_NINE;
        endfunction

        function bit is_plain(input logic [15:0] ch);
            return ch == CHAR_UNDERSCORE || ch == cssesc_pkg::CHAR_DASH || is_digit(ch) ||
                   (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ||
                   (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z);
        endfunction

        function void note_accepted_unit(input cssesc_pkg::in_item_t it);
            logic [15:0] ch;
            ch = it.code_unit;
            run_units.delete();
            if (it.first_of_ident)
            begin
                phase = AT_START;
                dropping = 1'b0;
            end
            if (dropping)
            begin
                run_units.delete();
            end
            else if (phase == AT_START && ch == cssesc_pkg::CHAR_DASH)
            begin
                if (it.last_of_ident)
                begin
                    stage(cssesc_pkg::CHAR_BACKSLASH, 1'b0);
                end
                stage(cssesc_pkg::CHAR_DASH, 1'b0);
                phase = AFTER_DASH;
            end
            else if (phase != IN_BODY && is_digit(ch))
            begin
                stage_hex_escape(ch);
                phase = IN_BODY;
            end
            else
            begin
                phase = IN_BODY;
                if (ch == cssesc_pkg::CHAR_NUL)
                begin
                    stage(cssesc_pkg::CHAR_NUL, 1'b1);
                    dropping = 1'b1;
                end
                else if (ch < cssesc_pkg::CTRL_LIMIT ||
                         (ch >= cssesc_pkg::CHAR_DEL && ch < cssesc_pkg::C1_LIMIT))
                begin
                    stage_hex_escape(ch);
                end
                else
                begin
                    if (ch < cssesc_pkg::CHAR_DEL && !is_plain(ch))
                    begin
                        stage(cssesc_pkg::CHAR_BACKSLASH, 1'b0);
                    end
                    stage(ch, 1'b0);
                end
            end
            if (run_units.size() > 0)
            begin
                run_units[run_units.size() - 1].last_of_run = 1'b1;
            end
            foreach (run_units[i])
            begin
                awaited.push_back(run_units[i]);
            end
            if (it.last_of_ident)
            begin
                phase = AT_START;
                dropping = 1'b0;
            end
        endfunction

        task check_emitted_unit(input cssesc_pkg::out_item_t got);
            cssesc_pkg::out_item_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result unit %h", got.out_unit));
                return;
            end
            want = awaited.pop_front();
            if (got.out_unit !== want.out_unit)
            begin
                report_mismatch($sformatf("out_unit %h, want %h", got.out_unit, want.out_unit));
            end
            if (got.ident_failed !== want.ident_failed)
            begin
                report_mismatch($sformatf("ident_failed %b, want %b on unit %h",
                                          got.ident_failed, want.ident_failed, want.out_unit));
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                report_mismatch($sformatf("last_of_run %b, want %b on unit %h",
                                          got.last_of_run, want.last_of_run, want.out_unit));
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  pop = 1'b0;
    logic                  full;
    logic                  empty;
    cssesc_pkg::in_item_t  item = '0;
    cssesc_pkg::out_item_t result;

    escape_scoreboard sb = new();
    int units_sent = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_long = 1'b0;

    css_identifier_escaper_core u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                sb.note_accepted_unit(item);
            end
            if (pop && !empty)
            begin
                sb.check_emitted_unit(result);
            end
        end
    end

    function automatic cssesc_pkg::in_item_t make_unit(input logic [15:0] ch,
                                                       input logic first, input logic last);
        cssesc_pkg::in_item_t it;
        it.code_unit = ch;
        it.first_of_ident = first;
        it.last_of_ident = last;
        return it;
    endfunction

    function automatic logic [15:0] random_code_unit(input bit at_head);
        if (at_head && $urandom_range(0, 3) == 0)
        begin
            return cssesc_pkg::CHAR_DASH;
        end
        case ($urandom_range(0, 19))
            0, 1, 2:    return CHAR_LOWER_A + 16'($urandom_range(0, 25));
            3, 4:       return CHAR_UPPER_A + 16'($urandom_range(0, 25));
            5, 6, 7:    return CHAR_ZERO + 16'($urandom_range(0, 9));
            8:          return cssesc_pkg::CHAR_DASH;
            9:          return CHAR_UNDERSCORE;
            10, 11:     return 16'($urandom_range(cssesc_pkg::CHAR_SPACE, CHAR_TILDE));
            12:         return 16'($urandom_range(1, cssesc_pkg::CTRL_LIMIT - 1));
            13:         return 16'($urandom_range(cssesc_pkg::CHAR_DEL,
                                                  cssesc_pkg::C1_LIMIT - 1));
            14:         return ($urandom_range(0, 2) == 0) ? cssesc_pkg::CHAR_NUL : CHAR_LOWER_A;
            15, 16:     return 16'($urandom_range(cssesc_pkg::C1_LIMIT, 16'hFFFF));
            default:    return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic send_unit(input cssesc_pkg::in_item_t it);
        item <= it;
        push <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (full);
        units_sent++;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic send_ident(input int len, input bit broken);
        cssesc_pkg::in_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it = make_unit(random_code_unit(i == 0 || i == 1), i == 0, i == len - 1);
            if (broken)
            begin
                it.first_of_ident = ($urandom_range(0, 3) == 0);
                it.last_of_ident = ($urandom_range(0, 3) == 0);
            end
            send_unit(it);
        end
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_long)
            begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_long = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_unit(make_unit(cssesc_pkg::CHAR_DASH, 1'b1, 1'b1));
        send_unit(make_unit(cssesc_pkg::CHAR_DASH, 1'b1, 1'b0));
        send_unit(make_unit(CHAR_ZERO + 16'd1, 1'b0, 1'b0));
        send_unit(make_unit(CHAR_LOWER_A, 1'b0, 1'b1));
        send_unit(make_unit(CHAR_ZERO + 16'd5, 1'b1, 1'b0));
        send_unit(make_unit(cssesc_pkg::CHAR_DASH, 1'b0, 1'b0));
        send_unit(make_unit(16'h0001, 1'b0, 1'b0));
        send_unit(make_unit(16'h001F, 1'b0, 1'b0));
        send_unit(make_unit(cssesc_pkg::CHAR_DEL, 1'b0, 1'b0));
        send_unit(make_unit(16'h009F, 1'b0, 1'b0));
        send_unit(make_unit(cssesc_pkg::C1_LIMIT, 1'b0, 1'b0));
        send_unit(make_unit(16'hFFFF, 1'b0, 1'b0));
        send_unit(make_unit(CHAR_UNDERSCORE, 1'b0, 1'b0));
        send_unit(make_unit(cssesc_pkg::CHAR_SPACE, 1'b0, 1'b0));
        send_unit(make_unit(CHAR_TILDE, 1'b0, 1'b1));
        send_unit(make_unit(cssesc_pkg::CHAR_NUL, 1'b1, 1'b0));
        send_unit(make_unit(CHAR_LOWER_A, 1'b0, 1'b0));
        send_unit(make_unit(CHAR_LOWER_A + 16'd1, 1'b0, 1'b1));
        send_unit(make_unit(CHAR_LOWER_Z - 16'd2, 1'b1, 1'b0));
        send_unit(make_unit(cssesc_pkg::CHAR_NUL, 1'b0, 1'b0));
        send_unit(make_unit(CHAR_LOWER_Z - 16'd1, 1'b0, 1'b1));
        send_unit(make_unit(CHAR_ZERO + 16'd3, 1'b0, 1'b1));
        send_unit(make_unit(CHAR_LOWER_A, 1'b1, 1'b0));
        send_unit(make_unit(cssesc_pkg::CHAR_DASH, 1'b1, 1'b0));
        send_unit(make_unit(CHAR_NINE, 1'b0, 1'b1));
        wait_for_drain();

        while (units_sent < 290)
        begin
            send_ident($urandom_range(1, 8), $urandom_range(0, 5) == 0);
        end

        tx_idle_on = 1'b0;
        hold_long = 1'b1;
        for (int i = 0; i < 16; i++)
        begin
            send_unit(make_unit(16'($urandom_range(1, cssesc_pkg::CTRL_LIMIT - 1)),
                                i == 0, i == 15));
        end
        tx_idle_on = 1'b1;

        while (units_sent < 310)
        begin
            send_ident($urandom_range(1, 8), $urandom_range(0, 5) == 0);
        end

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (units_sent < 360)
        begin
            send_ident($urandom_range(1, 8), $urandom_range(0, 5) == 0);
        end

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.report_mismatch($sformatf("%0d expected units never came", sb.pending()));
        end
        if (sb.mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[css_identifier_escaper_core.f]
rtl/cssesc_pkg.sv
rtl/cssesc_front.sv
rtl/cssesc_cmd_queue.sv
rtl/cssesc_back.sv
rtl/css_identifier_escaper_core.sv
bench/css_identifier_escaper_core_test.sv
